>>> rtl/core/first_fit_page_allocator_unit_defines.svh
// ----------------------------------------------------------------------------
// First-fit page allocator: assertion macros
// Concurrent check wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_PAGE_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_PAGE_ALLOCATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define FFPA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define FFPA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FFPA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define FFPA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/core/ffpa_pkg.sv
// ----------------------------------------------------------------------------
// First-fit page allocator package
// Widths, request/response types, free-list entry type and codes.
// ----------------------------------------------------------------------------
package ffpa_pkg;

  localparam int unsigned FREE_ENTRIES = 64;
  localparam int unsigned IDX_W        = $clog2(FREE_ENTRIES);
  localparam int unsigned CNT_W        = $clog2(FREE_ENTRIES + 1);
  localparam int unsigned OFF_W        = 31;
  localparam int unsigned SIZE_W       = 32;
  localparam int unsigned STAT_W       = 3;
  localparam int unsigned SHIFT_W      = 5;
  localparam int unsigned CFG_IDX_W    = 1;

  localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
  localparam logic [STAT_W-1:0] STAT_ZERO    = 3'd1;
  localparam logic [STAT_W-1:0] STAT_EXHAUST = 3'd2;
  localparam logic [STAT_W-1:0] STAT_IGNORED = 3'd3;
  localparam logic [STAT_W-1:0] STAT_FULL    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BYTES = 1'd1;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [SIZE_W-1:0] req_size;
    logic [OFF_W-1:0]  block_offset;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [OFF_W-1:0]  granted_offset;
  } rsp_t;

  typedef struct packed {
    logic [OFF_W-1:0]  start;
    logic [SIZE_W-1:0] len;
  } entry_t;

  // where the tail of the chain is fed from once the edit point is passed
  typedef enum logic [1:0] {
    SEL_HEAD,
    SEL_NEXT,
    SEL_HOLD
  } sel_e;

endpackage

>>> rtl/core/ffpa_cell.sv
// ----------------------------------------------------------------------------
// First-fit page allocator: list cell
// Holds one free-list entry; loads its right neighbour on shift.
// ----------------------------------------------------------------------------
module ffpa_cell (
  input  logic            clk_i,
  input  logic            shift_i,
  input  ffpa_pkg::entry_t ent_i,
  output ffpa_pkg::entry_t ent_o
);
  import ffpa_pkg::*;

  entry_t ent_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      ent_q <= ent_i;
    end
  end

  assign ent_o = ent_q;

endmodule

>>> rtl/core/ffpa_chain.sv
// ----------------------------------------------------------------------------
// First-fit page allocator: cell chain
// Ring of list cells moving towards cell 0; the tail takes the pushed entry.
// ----------------------------------------------------------------------------
module ffpa_chain (
  input  logic             clk_i,
  input  logic             shift_i,
  input  ffpa_pkg::entry_t push_i,
  output ffpa_pkg::entry_t head0_o,
  output ffpa_pkg::entry_t head1_o
);
  import ffpa_pkg::*;

  entry_t ent [FREE_ENTRIES];

  for (genvar i = 0; i < FREE_ENTRIES; i++) begin : g_cell
    entry_t nb;
    if (i == FREE_ENTRIES - 1) begin : g_tail
      assign nb = push_i;
    end else begin : g_mid
      assign nb = ent[i+1];
    end
    ffpa_cell u_cell (
      .clk_i  (clk_i),
      .shift_i(shift_i),
      .ent_i  (nb),
      .ent_o  (ent[i])
    );
  end

  assign head0_o = ent[0];
  assign head1_o = ent[1];

endmodule

>>> rtl/core/first_fit_page_allocator_unit.sv
// ----------------------------------------------------------------------------
// First-fit page allocator
// Page-rounded first-fit allocation with split, bump fallback, and
// offset-ordered free with neighbour merging, over a chain of list cells.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                    Payload
// request   in         start & !busy                req_i (req_t)
// response  out        rsp_valid_o, one cycle       rsp_o (rsp_t)
// config    in         cfg_we_i                     cfg_idx_i, cfg_wdata_i
//
// Zero-size, ignored and list-full requests answer the cycle after accept.
// Others shift the cell ring through one full turn in ST_SCAN, then ST_FIN
// registers the response and the new list count.
// busy is high in ST_SCAN and ST_FIN; requests answered from idle never raise it.
// Reset clears the list count and watermark; cell contents are not reset.
// The response cannot be stalled.
// ----------------------------------------------------------------------------
`include "first_fit_page_allocator_unit_defines.svh"

module first_fit_page_allocator_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  ffpa_pkg::req_t                 req_i,
  output logic                           rsp_valid_o,
  output ffpa_pkg::rsp_t                 rsp_o,
  input  logic                           cfg_we_i,
  input  logic [ffpa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ffpa_pkg::SIZE_W-1:0]    cfg_wdata_i
);
  import ffpa_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_e;

  localparam logic [SIZE_W-1:0] SPACE_END = 32'h8000_0000;

  state_e              state_q, state_d;
  logic [IDX_W-1:0]    k_q, k_d;
  logic [SIZE_W:0]     need_q, need_d;
  logic [OFF_W-1:0]    off_q, off_d;
  logic [SIZE_W-1:0]   flen_q, flen_d;
  logic                free_q, free_d;
  logic                found_q, found_d;
  logic                after_q, after_d;
  sel_e                sel_q, sel_d;
  entry_t              hold_q;
  logic [OFF_W-1:0]    grant_q, grant_d;
  logic [CNT_W-1:0]    cnew_q, cnew_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [SIZE_W-1:0]   wm_q, wm_d;
  logic [SHIFT_W-1:0]  ps_q;
  logic [SIZE_W-1:0]   pool_q;
  rsp_t                rsp_q, rsp_d;
  logic                rv_q, rv_d;

  entry_t              e0, e1, push;
  logic                v0, v1, shift;
  logic                accept;
  logic [SIZE_W:0]     mask, need_in;
  logic [SIZE_W-1:0]   space, flen_in, limit;
  logic [SIZE_W+1:0]   nw;
  logic                bef0, bef1, touch;
  logic [SIZE_W-1:0]   mlen;
  logic                mn;

  ffpa_chain u_chain (
    .clk_i  (clk_i),
    .shift_i(shift),
    .push_i (push),
    .head0_o(e0),
    .head1_o(e1)
  );

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);
  assign shift  = (state_q == ST_SCAN);
  assign v0     = CNT_W'(k_q) < cnt_q;
  assign v1     = (CNT_W'(k_q) + CNT_W'(1)) < cnt_q;

  // page rounding at 33 bits, never wraps
  assign mask    = (33'd1 << ps_q) - 33'd1;
  assign need_in = ({1'b0, req_i.req_size} + mask) & ~mask;
  assign space   = SPACE_END - {1'b0, req_i.block_offset};
  assign flen_in = (need_in > {1'b0, space}) ? space : need_in[SIZE_W-1:0];
  assign limit   = (pool_q > SPACE_END) ? SPACE_END : pool_q;
  assign nw      = {2'b0, wm_q} + {1'b0, need_q};

  assign bef0  = v0 && (e0.start < off_q);
  assign bef1  = v1 && (e1.start < off_q);
  assign touch = ({2'b0, e0.start} + {1'b0, e0.len}) == {2'b0, off_q};

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    need_d  = need_q;
    off_d   = off_q;
    flen_d  = flen_q;
    free_d  = free_q;
    found_d = found_q;
    after_d = after_q;
    sel_d   = sel_q;
    grant_d = grant_q;
    cnew_d  = cnew_q;
    cnt_d   = cnt_q;
    wm_d    = wm_q;
    rsp_d   = rsp_q;
    rv_d    = 1'b0;
    push    = e0;
    mlen    = '0;
    mn      = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          need_d  = need_in;
          off_d   = req_i.block_offset;
          flen_d  = flen_in;
          free_d  = req_i.req_type;
          found_d = 1'b0;
          after_d = 1'b0;
          sel_d   = SEL_HEAD;
          grant_d = '0;
          k_d     = '0;
          rsp_d.granted_offset = '0;
          if (req_i.req_type == REQ_ALLOC) begin
            cnew_d = cnt_q;
            if (req_i.req_size == '0) begin
              rsp_d.status = STAT_ZERO;
              rv_d = 1'b1;
            end else begin
              state_d = ST_SCAN;
            end
          end else begin
            cnew_d = cnt_q + CNT_W'(1);
            if ({1'b0, req_i.block_offset} >= pool_q) begin
              rsp_d.status = STAT_IGNORED;
              rv_d = 1'b1;
            end else if (cnt_q >= CNT_W'(FREE_ENTRIES)) begin
              rsp_d.status = STAT_FULL;
              rv_d = 1'b1;
            end else begin
              state_d = ST_SCAN;
            end
          end
        end
      end

      ST_SCAN: begin
        // default tail feed once past the edit point
        case (sel_q)
          SEL_HEAD: push = e0;
          SEL_NEXT: push = e1;
          SEL_HOLD: push = hold_q;
          default:  push = e0;
        endcase
        if (!free_q) begin
          if (!found_q) begin
            push = e0;
            if (v0 && ({1'b0, e0.len} >= need_q)) begin
              found_d = 1'b1;
              grant_d = e0.start;
              if ({1'b0, e0.len} > need_q) begin
                push.start = e0.start + need_q[OFF_W-1:0];
                push.len   = e0.len - need_q[SIZE_W-1:0];
                sel_d      = SEL_HEAD;
              end else begin
                push   = e1;
                sel_d  = SEL_NEXT;
                cnew_d = cnew_q - CNT_W'(1);
              end
            end
          end
        end else if (!after_q) begin
          push = e0;
          if (bef0) begin
            if (!bef1 && touch) begin
              // merge with the block before, then maybe the one after
              mlen = e0.len + flen_q;
              mn   = v1 && (({2'b0, e0.start} + {1'b0, mlen}) == {2'b0, e1.start});
              push.start = e0.start;
              push.len   = mn ? (mlen + e1.len) : mlen;
              after_d    = 1'b1;
              sel_d      = mn ? SEL_NEXT : SEL_HEAD;
              cnew_d     = mn ? (cnew_q - CNT_W'(2)) : (cnew_q - CNT_W'(1));
            end
          end else begin
            mn = v0 && (({2'b0, off_q} + {1'b0, flen_q}) == {2'b0, e0.start});
            push.start = off_q;
            push.len   = mn ? (flen_q + e0.len) : flen_q;
            after_d    = 1'b1;
            sel_d      = mn ? SEL_HEAD : SEL_HOLD;
            cnew_d     = mn ? (cnew_q - CNT_W'(1)) : cnew_q;
          end
        end
        k_d = k_q + IDX_W'(1);
        if (k_q == IDX_W'(FREE_ENTRIES - 1)) begin
          state_d = ST_FIN;
        end
      end

      ST_FIN: begin
        cnt_d   = cnew_q;
        rv_d    = 1'b1;
        state_d = ST_IDLE;
        rsp_d.status         = STAT_OK;
        rsp_d.granted_offset = grant_q;
        if (!free_q && !found_q) begin
          if (nw > {2'b0, limit}) begin
            rsp_d.status         = STAT_EXHAUST;
            rsp_d.granted_offset = '0;
          end else begin
            rsp_d.granted_offset = wm_q[OFF_W-1:0];
            wm_d                 = nw[SIZE_W-1:0];
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      need_q  <= '0;
      off_q   <= '0;
      flen_q  <= '0;
      free_q  <= 1'b0;
      found_q <= 1'b0;
      after_q <= 1'b0;
      sel_q   <= SEL_HEAD;
      grant_q <= '0;
      cnew_q  <= '0;
      cnt_q   <= '0;
      wm_q    <= '0;
      ps_q    <= 5'd12;
      pool_q  <= 32'h1000_0000;
      rsp_q   <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      need_q  <= need_d;
      off_q   <= off_d;
      flen_q  <= flen_d;
      free_q  <= free_d;
      found_q <= found_d;
      after_q <= after_d;
      sel_q   <= sel_d;
      grant_q <= grant_d;
      cnew_q  <= cnew_d;
      cnt_q   <= cnt_d;
      wm_q    <= wm_d;
      rsp_q   <= rsp_d;
      rv_q    <= rv_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PAGE_SHIFT: ps_q   <= cfg_wdata_i[SHIFT_W-1:0];
          CFG_POOL_BYTES: pool_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // previous head, fed back when an inserted block pushes the list along
  always_ff @(posedge clk_i) begin
    if (shift) begin
      hold_q <= e0;
    end
  end

  assign rsp_valid_o = rv_q;
  assign rsp_o       = rsp_q;

  `FFPA_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CNT_W'(FREE_ENTRIES), "list count overflow")
  `FFPA_ASSERT_NXT(a_fin_resp, clk_i, rst_ni, state_q == ST_FIN, rsp_valid_o && !busy, "no response after scan")
  `FFPA_ASSERT_IMP(a_resp_src, clk_i, rst_ni, rsp_valid_o, $past(accept) || $past(state_q == ST_FIN), "stray response")
  `FFPA_ASSERT_IMP(a_scan_busy, clk_i, rst_ni, state_q == ST_SCAN, !rsp_valid_o, "response during scan")

endmodule

>>> verif/first_fit_page_allocator_unit_tb.sv
// ----------------------------------------------------------------------------
// First-fit page allocator testbench
// Drives alloc/free requests through a directed table and then random
// traffic. Each response is compared with a software model of the free list,
// the watermark and the page rounding.
// ----------------------------------------------------------------------------
module first_fit_page_allocator_unit_tb;
  import ffpa_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned N_RANDOM     = 930;
  localparam int unsigned N_DIRECTED   = 22;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  req_t              req_i;
  logic              rsp_valid_o;
  rsp_t              rsp_o;
  logic              cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [SIZE_W-1:0] cfg_wdata_i;

  first_fit_page_allocator_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // allocator mirror
  logic [4:0]        mdl_shift;
  logic [31:0]       mdl_pool;
  logic [OFF_W-1:0]  fl_start [FREE_ENTRIES];
  logic [SIZE_W-1:0] fl_len   [FREE_ENTRIES];
  int unsigned       fl_count;
  logic [31:0]       mdl_wmark;

  rsp_t        pending_rsp [$];
  int unsigned n_errors;
  int unsigned cycle_cnt = 0;

  typedef struct {
    logic        kind;
    logic [31:0] size;
    logic [30:0] offset;
    logic        known;
    logic [2:0]  status;
    logic [30:0] granted;
  } vec_t;

  vec_t dir_tbl [N_DIRECTED];

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] page_round(logic [63:0] sz);
    logic [63:0] mask;
    mask = (64'd1 << mdl_shift) - 64'd1;
    return (sz + mask) & ~mask;
  endfunction

  function automatic void drop_entry(int unsigned i);
    for (int unsigned k = i; k + 1 < fl_count; k++) begin
      fl_start[k] = fl_start[k+1];
      fl_len[k]   = fl_len[k+1];
    end
    fl_count--;
  endfunction

  function automatic rsp_t alloc_free_predict(req_t r);
    rsp_t        res;
    logic [63:0] need, lim, nw, off, len;
    int unsigned pos;
    bit          done;
    res = '0;
    done = 0;
    if (r.req_type == REQ_ALLOC) begin
      if (r.req_size == 0) begin
        res.status = STAT_ZERO;
        return res;
      end
      need = page_round({32'd0, r.req_size});
      for (int unsigned i = 0; i < fl_count && !done; i++) begin
        if ({32'd0, fl_len[i]} >= need) begin
          res.granted_offset = fl_start[i];
          if ({32'd0, fl_len[i]} > need) begin
            fl_start[i] = fl_start[i] + need[30:0];
            fl_len[i]   = fl_len[i] - need[31:0];
          end else begin
            drop_entry(i);
          end
          done = 1;
        end
      end
      if (done) begin
        res.status = STAT_OK;
        return res;
      end
      lim = {32'd0, mdl_pool};
      if (lim > 64'h8000_0000) lim = 64'h8000_0000;
      nw = {32'd0, mdl_wmark} + need;
      if (nw > lim) begin
        res.status = STAT_EXHAUST;
        return res;
      end
      res.status = STAT_OK;
      res.granted_offset = mdl_wmark[30:0];
      mdl_wmark = nw[31:0];
      return res;
    end
    off = {33'd0, r.block_offset};
    if (off >= {32'd0, mdl_pool}) begin
      res.status = STAT_IGNORED;
      return res;
    end
    if (fl_count >= FREE_ENTRIES) begin
      res.status = STAT_FULL;
      return res;
    end
    len = page_round({32'd0, r.req_size});
    if (len > 64'h8000_0000 - off) len = 64'h8000_0000 - off;
    pos = 0;
    while (pos < fl_count && {33'd0, fl_start[pos]} < off) pos++;
    for (int unsigned k = fl_count; k > pos; k--) begin
      fl_start[k] = fl_start[k-1];
      fl_len[k]   = fl_len[k-1];
    end
    fl_start[pos] = off[30:0];
    fl_len[pos]   = len[31:0];
    fl_count++;
    if (pos > 0 && {33'd0, fl_start[pos-1]} + fl_len[pos-1] == off) begin
      fl_len[pos-1] = fl_len[pos-1] + len[31:0];
      drop_entry(pos);
      pos--;
    end
    if (pos + 1 < fl_count &&
        {33'd0, fl_start[pos]} + fl_len[pos] == {33'd0, fl_start[pos+1]}) begin
      fl_len[pos] = fl_len[pos] + fl_len[pos+1];
      drop_entry(pos + 1);
    end
    res.status = STAT_OK;
    return res;
  endfunction

  // response checker
  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    if (rst_ni && rsp_valid_o) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected response status=%0d", rsp_o.status);
        n_errors++;
      end else begin
        exp_rsp = pending_rsp.pop_front();
        if (rsp_o.status !== exp_rsp.status) begin
          $error("status: expected %0d, got %0d", exp_rsp.status, rsp_o.status);
          n_errors++;
        end
        if (rsp_o.granted_offset !== exp_rsp.granted_offset) begin
          $error("granted_offset: expected %0h, got %0h",
                 exp_rsp.granted_offset, rsp_o.granted_offset);
          n_errors++;
        end
      end
    end
  end

  task automatic drain_wait();
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_PAGE_SHIFT) mdl_shift = val[4:0];
    else mdl_pool = val;
    @(posedge clk_i);
  endtask

  // issue one request; held until accepted, prediction made at acceptance
  // start stays high afterwards until the next request or the drain
  task automatic issue_req(req_t r, bit gaps, bit known, rsp_t forced);
    rsp_t p;
    if (gaps && ($urandom_range(0, 3) == 0)) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    p = alloc_free_predict(r);
    if (known && p != forced) begin
      $error("table row disagrees with mirror: status expected %0d", forced.status);
      n_errors++;
    end
    pending_rsp = {pending_rsp, p};
  endtask

  function automatic req_t rand_req(int unsigned shift_hi);
    req_t r;
    int unsigned sel;
    r.req_type = $urandom_range(0, 2) == 0 ? REQ_ALLOC : REQ_FREE;
    if ($urandom_range(0, 1)) r.req_type = REQ_ALLOC;
    sel = $urandom_range(0, 19);
    if (sel == 0) r.req_size = $urandom();
    else if (sel == 1) r.req_size = 0;
    else r.req_size = $urandom_range(1, 6) << shift_hi;
    sel = $urandom_range(0, 19);
    if (sel == 0) r.block_offset = $urandom();
    else if (sel < 12 && mdl_wmark > 0)
      r.block_offset = ($urandom() % mdl_wmark) & ~((31'd1 << mdl_shift) - 1);
    else r.block_offset = $urandom_range(0, 2000) << mdl_shift;
    return r;
  endfunction

  initial begin
    req_t r;
    rsp_t f;
    start       = 1'b0;
    req_i       = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_PAGE_SHIFT;
    cfg_wdata_i = '0;
    n_errors    = 0;
    mdl_shift   = 5'd12;
    mdl_pool    = 32'h1000_0000;
    fl_count    = 0;
    mdl_wmark   = 0;
    rst_ni      = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // kind size offset known status granted
    dir_tbl = '{
      '{REQ_ALLOC, 32'd0,          31'd0,          1, STAT_ZERO,    31'd0},
      '{REQ_ALLOC, 32'd1,          31'd0,          1, STAT_OK,      31'd0},
      '{REQ_ALLOC, 32'h1000,       31'd0,          1, STAT_OK,      31'h1000},
      '{REQ_ALLOC, 32'h1001,       31'd0,          1, STAT_OK,      31'h2000},
      '{REQ_ALLOC, 32'hFFFF_FFFF,  31'd0,          1, STAT_EXHAUST, 31'd0},
      '{REQ_FREE,  32'h1000,       31'h7FFF_FFFF,  1, STAT_IGNORED, 31'd0},
      '{REQ_FREE,  32'h1000,       31'h1000,       0, 0, 0},
      '{REQ_FREE,  32'h1000,       31'h0,          0, 0, 0},
      '{REQ_FREE,  32'h0,          31'h5000,       0, 0, 0},
      '{REQ_FREE,  32'h1,          31'h3000,       0, 0, 0},
      '{REQ_ALLOC, 32'h800,        31'd0,          0, 0, 0},
      '{REQ_ALLOC, 32'h1000,       31'd0,          0, 0, 0},
      '{REQ_ALLOC, 32'h2000,       31'd0,          0, 0, 0},
      '{REQ_FREE,  32'h8000_0000,  31'h0FFF_F000,  0, 0, 0},
      '{REQ_ALLOC, 32'h8000_0000,  31'd0,          0, 0, 0},
      '{REQ_FREE,  32'hFFFF_FFFF,  31'h2000,       0, 0, 0},
      '{REQ_ALLOC, 32'h3000,       31'h5555_5555,  0, 0, 0},
      '{REQ_FREE,  32'h1000,       31'h0FFF_FFFF,  0, 0, 0},
      '{REQ_ALLOC, 32'h7FFF_FFFF,  31'd0,          0, 0, 0},
      '{REQ_ALLOC, 32'h1000,       31'd0,          0, 0, 0},
      '{REQ_FREE,  32'h1000,       31'h1000_0000,  1, STAT_IGNORED, 31'd0},
      '{REQ_ALLOC, 32'h0,          31'h7FFF_FFFF,  1, STAT_ZERO,    31'd0}
    };
    foreach (dir_tbl[i]) begin
      r = '{dir_tbl[i].kind, dir_tbl[i].size, dir_tbl[i].offset};
      f = '{dir_tbl[i].status, dir_tbl[i].granted};
      issue_req(r, 0, dir_tbl[i].known, f);
    end
    drain_wait();

    // phases: shift/pool settings including extremes
    for (int ph = 0; ph < 6; ph++) begin
      int unsigned sh;
      case (ph)
        0: begin sh = 0;  cfg_write(CFG_POOL_BYTES, 32'h0000_4000); end
        1: begin sh = 16; cfg_write(CFG_POOL_BYTES, 32'h8000_0000); end
        2: begin sh = 31; cfg_write(CFG_POOL_BYTES, 32'hFFFF_FFFF); end
        3: begin sh = 4;  cfg_write(CFG_POOL_BYTES, 32'd0); end
        4: begin sh = 8;  cfg_write(CFG_POOL_BYTES, $urandom()); end
        default: begin sh = 12; cfg_write(CFG_POOL_BYTES, 32'h1000_0000); end
      endcase
      cfg_write(CFG_PAGE_SHIFT, sh);
      for (int n = 0; n < N_RANDOM / 6; n++) begin
        r = rand_req(sh > 20 ? 0 : sh);
        issue_req(r, ph < 5, 0, '0);
      end
      drain_wait();
    end

    if (pending_rsp.size() != 0) n_errors++;
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/ffpa_pkg.sv
rtl/core/ffpa_cell.sv
rtl/core/ffpa_chain.sv
rtl/core/first_fit_page_allocator_unit.sv
verif/first_fit_page_allocator_unit_tb.sv
